@@ rtl/segment_intersection_macros.svh @@
// assertion macros shared by the segment intersection rtl
// no dependencies
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define SI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment intersection assertion failed");

// next-cycle implication, disabled during reset
`define SI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment intersection assertion failed");

`endif

@@ rtl/si_pkg.sv @@
// widths, stage types and helpers for the segment intersection block
// no dependencies
package si_pkg;

   localparam int CW          = 16;            // coordinate width, Q12.4
   localparam int DIFF_W      = CW + 1;        // coordinate difference
   localparam int PROD_W      = 2 * DIFF_W;    // cross product term
   localparam int DEN_W       = PROD_W + 1;    // denominator and numerators
   localparam int REM_W       = DEN_W + CW;    // scaled numerator
   localparam int QSTEPS      = CW;            // quotient bits
   localparam int IDX_W       = $clog2(QSTEPS);
   localparam int GEOM_STAGES = 4;
   localparam int NUM_STAGES  = GEOM_STAGES + 1 + QSTEPS + 1;
   localparam int TOT_W       = CW + 3;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic                 found;
      logic                 parallel;
      coord_type            ax;
      coord_type            ay;
      logic                 negx;
      logic                 negy;
      logic [CW-1:0]        magx;
      logic [CW-1:0]        magy;
      logic [DEN_W-1:0]     den;
      logic [DEN_W-1:0]     na;
   } cls_type;

   typedef struct packed {
      logic                 found;
      logic                 parallel;
      coord_type            ax;
      coord_type            ay;
      logic                 negx;
      logic                 negy;
      logic [DEN_W-1:0]     den;
      logic [REM_W-1:0]     remx;
      logic [REM_W-1:0]     remy;
      logic [CW-1:0]        qx;
      logic [CW-1:0]        qy;
   } div_type;

   function automatic coord_type sat_coord(input logic signed [TOT_W-1:0] v);
      logic signed [TOT_W-1:0] lo;
      logic signed [TOT_W-1:0] hi;
      lo = -(TOT_W'(1) <<< (CW - 1));
      hi = (TOT_W'(1) <<< (CW - 1)) - TOT_W'(1);
      if (v < lo) return coord_type'(lo);
      if (v > hi) return coord_type'(hi);
      return coord_type'(v);
   endfunction

endpackage

@@ rtl/si_req_if.sv @@
// request channel: two segments, valid/ready handshake
// depends on si_pkg
interface si_req_if;
   logic               valid;
   logic               ready;
   si_pkg::coord_type  ax;
   si_pkg::coord_type  ay;
   si_pkg::coord_type  bx;
   si_pkg::coord_type  by_coord;
   si_pkg::coord_type  cx;
   si_pkg::coord_type  cy;
   si_pkg::coord_type  dx_end;
   si_pkg::coord_type  dy_end;

   modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx_end, dy_end,
                   input ready);
   modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, dx_end, dy_end,
                   output ready);
endinterface

@@ rtl/si_rsp_if.sv @@
// response channel: hit flags and point, valid/ready handshake
// depends on si_pkg
interface si_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic               parallel;
   si_pkg::coord_type  hit_x;
   si_pkg::coord_type  hit_y;

   modport source (output valid, found, parallel, hit_x, hit_y, input ready);
   modport sink   (input valid, found, parallel, hit_x, hit_y, output ready);
endinterface

@@ rtl/si_geom.sv @@
// differences, cross products, denominator/numerators and hit classification
// depends on si_pkg
module si_geom (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [si_pkg::GEOM_STAGES-1:0]        en,
   input  si_pkg::coord_type                     ax,
   input  si_pkg::coord_type                     ay,
   input  si_pkg::coord_type                     bx,
   input  si_pkg::coord_type                     by_coord,
   input  si_pkg::coord_type                     cx,
   input  si_pkg::coord_type                     cy,
   input  si_pkg::coord_type                     dx_end,
   input  si_pkg::coord_type                     dy_end,
   output logic [si_pkg::GEOM_STAGES-1:0]        v,
   output si_pkg::cls_type                       cls
);

   logic [si_pkg::GEOM_STAGES-1:0] v_ff, v_in;

   // stage 0: differences
   logic signed [si_pkg::DIFF_W-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, d3x_ff, d3y_ff;
   si_pkg::coord_type                ax0_ff, ay0_ff;
   // stage 1: products
   logic signed [si_pkg::PROD_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [si_pkg::DIFF_W-1:0] d1x1_ff, d1y1_ff;
   si_pkg::coord_type                ax1_ff, ay1_ff;
   // stage 2: den and numerators
   logic signed [si_pkg::DEN_W-1:0]  den_ff, na_ff, nb_ff;
   logic signed [si_pkg::DIFF_W-1:0] d1x2_ff, d1y2_ff;
   si_pkg::coord_type                ax2_ff, ay2_ff;
   // stage 3: classification
   si_pkg::cls_type                  cls_ff, cls_in;

   always_comb begin
      v_in[0] = in_valid;
      for (int k = 1; k < si_pkg::GEOM_STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < si_pkg::GEOM_STAGES; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1x_ff <= si_pkg::DIFF_W'(bx) - si_pkg::DIFF_W'(ax);
         d1y_ff <= si_pkg::DIFF_W'(by_coord) - si_pkg::DIFF_W'(ay);
         d2x_ff <= si_pkg::DIFF_W'(dx_end) - si_pkg::DIFF_W'(cx);
         d2y_ff <= si_pkg::DIFF_W'(dy_end) - si_pkg::DIFF_W'(cy);
         d3x_ff <= si_pkg::DIFF_W'(ax) - si_pkg::DIFF_W'(cx);
         d3y_ff <= si_pkg::DIFF_W'(ay) - si_pkg::DIFF_W'(cy);
         ax0_ff <= ax;
         ay0_ff <= ay;
      end
      if (en[1]) begin
         p0_ff   <= d2y_ff * d1x_ff;
         p1_ff   <= d2x_ff * d1y_ff;
         p2_ff   <= d2x_ff * d3y_ff;
         p3_ff   <= d2y_ff * d3x_ff;
         p4_ff   <= d1x_ff * d3y_ff;
         p5_ff   <= d1y_ff * d3x_ff;
         d1x1_ff <= d1x_ff;
         d1y1_ff <= d1y_ff;
         ax1_ff  <= ax0_ff;
         ay1_ff  <= ay0_ff;
      end
      if (en[2]) begin
         den_ff  <= si_pkg::DEN_W'(p0_ff) - si_pkg::DEN_W'(p1_ff);
         na_ff   <= si_pkg::DEN_W'(p2_ff) - si_pkg::DEN_W'(p3_ff);
         nb_ff   <= si_pkg::DEN_W'(p4_ff) - si_pkg::DEN_W'(p5_ff);
         d1x2_ff <= d1x1_ff;
         d1y2_ff <= d1y1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
      end
      if (en[3]) begin
         cls_ff <= cls_in;
      end
   end

   // parameter test without normalizing: same sign as den and no larger
   always_comb begin
      logic pos, zero, na_ok, nb_ok;
      logic signed [si_pkg::DIFF_W-1:0] ndx, ndy;
      pos   = !den_ff[si_pkg::DEN_W-1];
      zero  = (den_ff == '0);
      na_ok = pos ? (!na_ff[si_pkg::DEN_W-1] && (na_ff <= den_ff))
                  : ((na_ff[si_pkg::DEN_W-1] || (na_ff == '0)) && (na_ff >= den_ff));
      nb_ok = pos ? (!nb_ff[si_pkg::DEN_W-1] && (nb_ff <= den_ff))
                  : ((nb_ff[si_pkg::DEN_W-1] || (nb_ff == '0)) && (nb_ff >= den_ff));
      ndx   = -d1x2_ff;
      ndy   = -d1y2_ff;
      cls_in.found    = !zero && na_ok && nb_ok;
      cls_in.parallel = zero;
      cls_in.ax       = ax2_ff;
      cls_in.ay       = ay2_ff;
      cls_in.negx     = d1x2_ff[si_pkg::DIFF_W-1];
      cls_in.negy     = d1y2_ff[si_pkg::DIFF_W-1];
      cls_in.magx     = d1x2_ff[si_pkg::DIFF_W-1] ? ndx[si_pkg::CW-1:0] : d1x2_ff[si_pkg::CW-1:0];
      cls_in.magy     = d1y2_ff[si_pkg::DIFF_W-1] ? ndy[si_pkg::CW-1:0] : d1y2_ff[si_pkg::CW-1:0];
      cls_in.den      = pos ? den_ff : -den_ff;
      cls_in.na       = pos ? na_ff : -na_ff;
   end

   assign v   = v_ff;
   assign cls = cls_ff;

endmodule

@@ rtl/si_scale.sv @@
// scales the numerator by each segment-one extent, ahead of the divider
// depends on si_pkg
module si_scale (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  si_pkg::cls_type  cls,
   output logic             v,
   output si_pkg::div_type  dv
);

   logic            v_ff;
   si_pkg::div_type dv_ff, dv_in;

   always_comb begin
      dv_in.found    = cls.found;
      dv_in.parallel = cls.parallel;
      dv_in.ax       = cls.ax;
      dv_in.ay       = cls.ay;
      dv_in.negx     = cls.negx;
      dv_in.negy     = cls.negy;
      dv_in.den      = cls.den;
      dv_in.remx     = si_pkg::REM_W'(cls.na) * si_pkg::REM_W'(cls.magx);
      dv_in.remy     = si_pkg::REM_W'(cls.na) * si_pkg::REM_W'(cls.magy);
      dv_in.qx       = '0;
      dv_in.qy       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff <= dv_in;
      end
   end

   assign v  = v_ff;
   assign dv = dv_ff;

endmodule

@@ rtl/si_div_step.sv @@
// one restoring division stage: one quotient bit for both coordinates
// depends on si_pkg
module si_div_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [si_pkg::IDX_W-1:0] idx,
   input  logic                     in_valid,
   input  si_pkg::div_type          d_in,
   output logic                     v,
   output si_pkg::div_type          d_out
);

   logic            v_ff;
   si_pkg::div_type d_ff, d_next;

   always_comb begin
      logic [si_pkg::REM_W-1:0] shifted;
      logic                     gex, gey;
      shifted      = si_pkg::REM_W'(d_in.den) << idx;
      gex          = d_in.remx >= shifted;
      gey          = d_in.remy >= shifted;
      d_next       = d_in;
      d_next.remx  = gex ? d_in.remx - shifted : d_in.remx;
      d_next.remy  = gey ? d_in.remy - shifted : d_in.remy;
      d_next.qx    = d_in.qx | (si_pkg::CW'(gex) << idx);
      d_next.qy    = d_in.qy | (si_pkg::CW'(gey) << idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_next;
      end
   end

   assign v     = v_ff;
   assign d_out = d_ff;

endmodule

@@ rtl/segment_intersection.sv @@
// segment_intersection: exact two-segment intersection test in signed Q12.4
// takes a request with segment one (ax,ay)-(bx,by_coord) and segment two
// (cx,cy)-(dx_end,dy_end); returns found, parallel and the hit point on rsp
// one response per request, in request order
// path from request accept to response valid, each a registered stage:
// differences, cross products, den/numerators, classification, scaling,
// 16 restoring divider stages (one quotient bit each), final rounding stage
// throughput: one request per cycle unless all stages are full and rsp is
// held off; every stage has its own valid bit; the divider is fully unrolled
// stall: when rsp is held off, the output stage holds; stages behind it keep
// filling bubbles, so req_chan.ready drops only when every stage is full
// reset: synchronous, clears all valid bits; pipeline comes up empty and ready
// parallel or degenerate segments give parallel=1, found=0 and a zero point;
// a miss gives parallel=0, found=0 and a zero point
// depends on si_pkg, si_req_if, si_rsp_if, si_geom, si_scale, si_div_step
`include "segment_intersection_macros.svh"

module segment_intersection (
   input  logic        clock,
   input  logic        reset,
   si_req_if.sink      req_chan,
   si_rsp_if.source    rsp_chan
);

   localparam int LAST = si_pkg::NUM_STAGES - 1;
   localparam int SCL  = si_pkg::GEOM_STAGES;      // scaling stage index
   localparam int DIV0 = si_pkg::GEOM_STAGES + 1;  // first divider stage

   // per-stage valid and advance enables
   logic [si_pkg::NUM_STAGES-1:0] vall;
   logic [si_pkg::NUM_STAGES-1:0] en;

   logic [si_pkg::GEOM_STAGES-1:0] geom_v;
   si_pkg::cls_type                cls;
   logic                           scale_v;
   logic                           dvv [0:si_pkg::QSTEPS];
   si_pkg::div_type                dv  [0:si_pkg::QSTEPS];

   // output register
   logic               out_v_ff;
   logic               found_ff, found_in;
   logic               parallel_ff, parallel_in;
   si_pkg::coord_type  hit_x_ff, hit_x_in;
   si_pkg::coord_type  hit_y_ff, hit_y_in;

   // a stage may load when it is empty or the one ahead moves on
   always_comb begin
      en[LAST] = !vall[LAST] || rsp_chan.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !vall[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[0];

   // geometry front end: stages 0..3
   si_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .en       (en[si_pkg::GEOM_STAGES-1:0]),
      .ax       (req_chan.ax),
      .ay       (req_chan.ay),
      .bx       (req_chan.bx),
      .by_coord (req_chan.by_coord),
      .cx       (req_chan.cx),
      .cy       (req_chan.cy),
      .dx_end   (req_chan.dx_end),
      .dy_end   (req_chan.dy_end),
      .v        (geom_v),
      .cls      (cls)
   );

   assign vall[si_pkg::GEOM_STAGES-1:0] = geom_v;

   // numerator times extent, one multiplier per coordinate
   si_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .en       (en[SCL]),
      .in_valid (geom_v[si_pkg::GEOM_STAGES-1]),
      .cls      (cls),
      .v        (scale_v),
      .dv       (dv[0])
   );

   assign dvv[0]    = scale_v;
   assign vall[SCL] = scale_v;

   // quotient is below 2^CW since na <= den, so MSB first over CW stages
   for (genvar s = 0; s < si_pkg::QSTEPS; s++) begin : g_div
      si_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en[DIV0 + s]),
         .idx      (si_pkg::IDX_W'(si_pkg::QSTEPS - 1 - s)),
         .in_valid (dvv[s]),
         .d_in     (dv[s]),
         .v        (dvv[s+1]),
         .d_out    (dv[s+1])
      );
      assign vall[DIV0 + s] = dvv[s+1];
   end

   assign vall[LAST] = out_v_ff;

   // floor of the signed offset, then truncate the total toward zero
   always_comb begin
      si_pkg::div_type          d;
      logic                     rnzx, rnzy;
      logic signed [si_pkg::TOT_W-1:0] qx, qy, flx, fly, totx, toty;
      d    = dv[si_pkg::QSTEPS];
      rnzx = |d.remx;
      rnzy = |d.remy;
      qx   = $signed(si_pkg::TOT_W'(d.qx));
      qy   = $signed(si_pkg::TOT_W'(d.qy));
      flx  = d.negx ? -qx - si_pkg::TOT_W'(rnzx) : qx;
      fly  = d.negy ? -qy - si_pkg::TOT_W'(rnzy) : qy;
      totx = si_pkg::TOT_W'(d.ax) + flx;
      toty = si_pkg::TOT_W'(d.ay) + fly;
      if (totx[si_pkg::TOT_W-1] && rnzx) begin
         totx = totx + si_pkg::TOT_W'(1);
      end
      if (toty[si_pkg::TOT_W-1] && rnzy) begin
         toty = toty + si_pkg::TOT_W'(1);
      end
      found_in    = d.found;
      parallel_in = d.parallel;
      hit_x_in    = d.found ? si_pkg::sat_coord(totx) : '0;
      hit_y_in    = d.found ? si_pkg::sat_coord(toty) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en[LAST]) begin
         out_v_ff <= dvv[si_pkg::QSTEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         found_ff    <= found_in;
         parallel_ff <= parallel_in;
         hit_x_ff    <= hit_x_in;
         hit_y_ff    <= hit_y_in;
      end
   end

   assign rsp_chan.valid    = out_v_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.parallel = parallel_ff;
   assign rsp_chan.hit_x    = hit_x_ff;
   assign rsp_chan.hit_y    = hit_y_ff;

   // a hit is never reported on a zero denominator
   `SI_ASSERT_IMPLY(a_found_not_parallel, clock, reset,
      rsp_chan.valid && rsp_chan.found, !rsp_chan.parallel)
   // misses carry a zero point
   `SI_ASSERT_IMPLY(a_miss_zero_point, clock, reset,
      rsp_chan.valid && !rsp_chan.found, rsp_chan.hit_x == '0 && rsp_chan.hit_y == '0)
   // an empty output stage lets the whole pipe advance
   `SI_ASSERT_IMPLY(a_empty_out_ready, clock, reset, !out_v_ff, req_chan.ready)
   // a response held off keeps the output stage full
   `SI_ASSERT_NEXT(a_held_out_full, clock, reset, out_v_ff && !rsp_chan.ready, out_v_ff)

endmodule
